// File: sv/compass_heading_averaged_defines.svh
// Assertion macros for the compass heading block.
`ifndef COMPASS_HEADING_AVERAGED_DEFINES_SVH
`define COMPASS_HEADING_AVERAGED_DEFINES_SVH
`ifndef ASSERT_OFF
`define CHA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define CHA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CHA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CHA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: sv/cha_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cha_pkg
// Shared types and constants for the averaged compass heading block.
// ----------------------------------------------------------------------------
package cha_pkg;
    localparam int AVG_DEPTH   = 8;
    localparam int AVG_LOG2    = $clog2(AVG_DEPTH);
    localparam int SUM_W       = 16 + AVG_LOG2;
    localparam int CORDIC_N    = 16;
    localparam int STEP_W      = $clog2(CORDIC_N);
    localparam int CW          = 32;
    localparam int AW          = 24;

    typedef enum logic [2:0] {
        CFG_OFFSET_X = 3'd0,
        CFG_OFFSET_Y = 3'd1,
        CFG_OFFSET_Z = 3'd2,
        CFG_GAIN_X   = 3'd3,
        CFG_GAIN_Y   = 3'd4,
        CFG_GAIN_Z   = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CAL,
        ST_ROT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic shift;
        logic load;
    } t_ring_ctl;

    function automatic logic signed [AW-1:0] atan_q8(input logic [STEP_W-1:0] i);
        logic signed [AW-1:0] r;
        unique case (i)
            4'd0:  r = 24'sd1152000;
            4'd1:  r = 24'sd680065;
            4'd2:  r = 24'sd359328;
            4'd3:  r = 24'sd182400;
            4'd4:  r = 24'sd91554;
            4'd5:  r = 24'sd45822;
            4'd6:  r = 24'sd22916;
            4'd7:  r = 24'sd11459;
            4'd8:  r = 24'sd5730;
            4'd9:  r = 24'sd2865;
            4'd10: r = 24'sd1432;
            4'd11: r = 24'sd716;
            4'd12: r = 24'sd358;
            4'd13: r = 24'sd179;
            4'd14: r = 24'sd90;
            default: r = 24'sd45;
        endcase
        return r;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
        logic signed [15:0] r;
        if (v > 34'sd32767) r = 16'sh7fff;
        else if (v < -34'sd32768) r = 16'sh8000;
        else r = v[15:0];
        return r;
    endfunction
endpackage
`default_nettype wire

// File: sv/compass_heading_averaged.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// compass_heading_averaged
// Ring-averaged, calibrated magnetometer axes with an atan2 heading.
// ----------------------------------------------------------------------------
// One transfer per item, one result per item. Samples enter a chain of eight
// cells; the oldest drops off the end as sums are updated at the input
// transfer. From input transfer to result, an item passes through offset and
// gain, a CORDIC load, sixteen CORDIC iterations, a step to see it finish and
// the output load. The next item is accepted in the cycle after the result
// has been taken, so a new sample waits until the last result is taken.
module compass_heading_averaged (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [47:0]  s_axis_tdata,   // sample_x, sample_y, sample_z
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [63:0]       m_axis_tdata,   // cal_x, cal_y, cal_z, heading_centideg
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [2:0]   i_cfg_index,
    input  wire logic [15:0]  i_cfg_data
);
`include "compass_heading_averaged_defines.svh"
    localparam int D = cha_pkg::AVG_DEPTH;
    localparam int SW = cha_pkg::SUM_W;

    cha_pkg::t_state r_state, n_state;
    cha_pkg::t_ring_ctl ring_ctl;
    logic signed [47:0] chain [0:D];
    logic signed [SW-1:0] r_sum [3];
    logic signed [15:0] r_off [3];
    logic [15:0] r_gain [3];
    logic signed [15:0] r_cal [3];
    logic [63:0] r_out;
    logic r_oval, in_xfer, cal_go, cor_done;
    logic [15:0] heading;
    logic cor_busy_q;

    assign in_xfer = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == cha_pkg::ST_IDLE) && !r_oval;
    assign o_cfg_ready = 1'b1;
    assign ring_ctl = '{shift: in_xfer, load: in_xfer};
    assign chain[0] = s_axis_tdata;

    genvar g;
    generate
        for (g = 0; g < D; g++) begin : g_cell
            cha_cell u_cell (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ring_ctl),
                .i_prev(chain[g]), .o_data(chain[g+1])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_sum[a] <= '0;
                r_off[a] <= '0;
                r_gain[a] <= 16'd4096;
            end
        end else begin
            if (ring_ctl.load) begin
                for (int a = 0; a < 3; a++) begin
                    r_sum[a] <= r_sum[a] + SW'(signed'(s_axis_tdata[16*a +: 16]))
                        - SW'(signed'(chain[D][16*a +: 16]));
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    cha_pkg::CFG_OFFSET_X: r_off[0] <= i_cfg_data;
                    cha_pkg::CFG_OFFSET_Y: r_off[1] <= i_cfg_data;
                    cha_pkg::CFG_OFFSET_Z: r_off[2] <= i_cfg_data;
                    cha_pkg::CFG_GAIN_X:   r_gain[0] <= i_cfg_data;
                    cha_pkg::CFG_GAIN_Y:   r_gain[1] <= i_cfg_data;
                    cha_pkg::CFG_GAIN_Z:   r_gain[2] <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // truncating average, offset, gain
    logic signed [SW-1:0] adj [3];
    logic signed [15:0] avg [3];
    logic signed [15:0] dif [3];
    logic signed [33:0] prod [3];
    logic signed [33:0] padj [3];
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            adj[a] = r_sum[a] + (r_sum[a][SW-1] ? SW'(D - 1) : SW'(0));
            avg[a] = 16'(adj[a] >>> cha_pkg::AVG_LOG2);
            dif[a] = cha_pkg::sat16(34'(avg[a]) - 34'(r_off[a]));
            prod[a] = 34'(dif[a]) * signed'({18'd0, r_gain[a]});
            padj[a] = prod[a] + (prod[a][33] ? 34'sd4095 : 34'sd0);
        end
    end

    assign cal_go = (r_state == cha_pkg::ST_CAL);
    always_ff @(posedge i_clk) begin
        if (cal_go) begin
            for (int a = 0; a < 3; a++) r_cal[a] <= cha_pkg::sat16(padj[a] >>> 12);
        end
    end

    cha_cordic u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(r_state == cha_pkg::ST_ROT && !cor_busy_q),
        .i_x(r_cal[0]), .i_y(r_cal[1]),
        .o_done(cor_done), .o_heading(heading)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) cor_busy_q <= 1'b0;
        else if (r_state != cha_pkg::ST_ROT) cor_busy_q <= 1'b0;
        else cor_busy_q <= 1'b1;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cha_pkg::ST_IDLE: if (in_xfer) n_state = cha_pkg::ST_CAL;
            cha_pkg::ST_CAL:  n_state = cha_pkg::ST_ROT;
            cha_pkg::ST_ROT:  if (cor_done) n_state = cha_pkg::ST_OUT;
            cha_pkg::ST_OUT:  n_state = cha_pkg::ST_IDLE;
            default:          n_state = cha_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cha_pkg::ST_IDLE;
            r_oval <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == cha_pkg::ST_OUT) begin
                r_oval <= 1'b1;
                r_out <= {heading, r_cal[2], r_cal[1], r_cal[0]};
            end else if (m_axis_tready) begin
                r_oval <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_oval;
    assign m_axis_tdata = r_out;

    `CHA_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, r_state != cha_pkg::ST_IDLE, !s_axis_tready)
    `CHA_ASSERT_NXT(a_accept_to_cal, i_clk, i_rst_n, in_xfer, r_state == cha_pkg::ST_CAL)
    `CHA_ASSERT_NXT(a_out_loads, i_clk, i_rst_n, r_state == cha_pkg::ST_OUT, m_axis_tvalid)
endmodule
`default_nettype wire

// File: sv/cha_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cha_cell
// One ring cell: holds one sample and hands it to its neighbor.
// ----------------------------------------------------------------------------
module cha_cell (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire cha_pkg::t_ring_ctl  i_ctl,
    input  wire logic signed [47:0]  i_prev,
    output logic signed [47:0]       o_data
);
    logic signed [47:0] r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data <= '0;
        end else if (i_ctl.shift) begin
            r_data <= i_prev;
        end
    end

    assign o_data = r_data;
endmodule
`default_nettype wire

// File: sv/cha_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cha_cordic
// Iterative vectoring CORDIC, one rotation per cycle.
// ----------------------------------------------------------------------------
module cha_cordic (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic signed [15:0]  i_x,
    input  wire logic signed [15:0]  i_y,
    output logic                     o_done,
    output logic [15:0]              o_heading
);
    localparam int CW = cha_pkg::CW;
    localparam int AW = cha_pkg::AW;

    logic signed [CW-1:0] r_x, r_y, n_x, n_y;
    logic signed [AW-1:0] r_acc, n_acc;
    logic [cha_pkg::STEP_W-1:0] r_step;
    logic r_busy, r_zero;
    logic signed [CW-1:0] x0, y0, dx, dy;
    logic signed [AW-1:0] rnd;
    logic signed [AW-9:0] cd;
    logic [15:0] wrapped;

    assign x0 = {{(CW-30){i_x[15]}}, i_x, 14'd0};
    assign y0 = {{(CW-30){i_y[15]}}, i_y, 14'd0};
    assign dx = r_y >>> r_step;
    assign dy = r_x >>> r_step;

    always_comb begin
        if (r_y > 0) begin
            n_x = r_x + dx;
            n_y = r_y - dy;
            n_acc = r_acc + cha_pkg::atan_q8(r_step);
        end else begin
            n_x = r_x - dx;
            n_y = r_y + dy;
            n_acc = r_acc - cha_pkg::atan_q8(r_step);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_step <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_zero <= (i_x == 0) && (i_y == 0);
                if (i_x[15]) begin
                    r_x <= -x0;
                    r_y <= -y0;
                    r_acc <= 24'sd4608000;
                end else begin
                    r_x <= x0;
                    r_y <= y0;
                    r_acc <= '0;
                end
            end else if (r_busy) begin
                r_x <= n_x;
                r_y <= n_y;
                r_acc <= n_acc;
                r_step <= r_step + 1'b1;
                if (r_step == cha_pkg::STEP_W'(cha_pkg::CORDIC_N - 1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign rnd = r_acc + 24'sd128;
    assign cd  = rnd[AW-1:8];

    always_comb begin
        if (r_zero) wrapped = '0;
        else if (cd < 0) wrapped = 16'(17'(cd) + 17'sd36000);
        else if (17'(cd) >= 17'sd36000) wrapped = 16'(17'(cd) - 17'sd36000);
        else wrapped = 16'(cd);
    end

    assign o_heading = wrapped;
endmodule
`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the averaged compass heading block: samples stream in, each
// calibrated result and heading is compared with a local ring-average,
// offset, gain and CORDIC computation. Offsets and gains are rewritten
// between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;   // sample_x, sample_y, sample_z
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // cal_x, cal_y, cal_z, heading_centideg
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    compass_heading_averaged uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    typedef struct packed {
        logic [15:0] heading;
        logic [15:0] cz;
        logic [15:0] cy;
        logic [15:0] cx;
    } t_result;

    typedef struct {
        logic [47:0] sample;
        bit          known;
        t_result     res;
    } t_row;

    // predictor state
    int          ring [8][3];
    int          ring_ptr;
    int          axis_sum [3];
    int          offs [3];
    longint      gains [3];
    longint      atan_tab [16] = '{1152000, 680065, 359328, 182400, 91554, 45822,
                                   22916, 11459, 5730, 2865, 1432, 716, 358,
                                   179, 90, 45};

    t_result     expected_q [$];
    int          n_fail;
    int          src_idle_pct;
    int          snk_idle_pct;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #500ms;
        $display("tb: failure");
        $finish;
    end

    function automatic longint clamp16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint fshift(longint v, int k);
        return v >>> k;
    endfunction

    function automatic logic [15:0] heading_cd(longint cx, longint cy);
        longint x, y, acc, dx, dy, cd;
        x = cx * 16384;
        y = cy * 16384;
        acc = 0;
        if (cx == 0 && cy == 0) return 16'd0;
        if (x < 0) begin
            x = -x;
            y = -y;
            acc = 18000 * 256;
        end
        for (int i = 0; i < 16; i++) begin
            dx = fshift(y, i);
            dy = fshift(x, i);
            if (y > 0) begin
                x += dx;
                y -= dy;
                acc += atan_tab[i];
            end else begin
                x -= dx;
                y += dy;
                acc -= atan_tab[i];
            end
        end
        cd = fshift(acc + 128, 8);
        if (cd < 0) cd += 36000;
        if (cd >= 36000) cd -= 36000;
        return cd[15:0];
    endfunction

    function automatic t_result calibrate_sample(logic [47:0] smp);
        t_result r;
        longint cal [3];
        longint avg, diff, prod;
        int s;
        for (int a = 0; a < 3; a++) begin
            s = $signed(smp[16*a +: 16]);
            axis_sum[a] = axis_sum[a] - ring[ring_ptr][a] + s;
            ring[ring_ptr][a] = s;
            avg = axis_sum[a] / 8;
            diff = clamp16(avg - offs[a]);
            prod = (diff * gains[a]) / 4096;
            cal[a] = clamp16(prod);
        end
        ring_ptr = (ring_ptr + 1) % 8;
        r.cx = cal[0][15:0];
        r.cy = cal[1][15:0];
        r.cz = cal[2][15:0];
        r.heading = heading_cd(cal[0], cal[1]);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        n_fail++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (expected_q.size() == 0) begin
                $display("unexpected transfer on result side");
                n_fail++;
            end else begin
                want = expected_q.pop_front();
                if (got.cx != want.cx) report_mismatch("cal_x", got.cx, want.cx);
                if (got.cy != want.cy) report_mismatch("cal_y", got.cy, want.cy);
                if (got.cz != want.cz) report_mismatch("cal_z", got.cz, want.cz);
                if (got.heading != want.heading)
                    report_mismatch("heading", got.heading, want.heading);
            end
        end
    end

    // receiver stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) m_axis_tready <= 1'b0;
        else m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    task automatic write_reg(cha_pkg::t_cfg_idx idx, logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx <= cha_pkg::CFG_OFFSET_Z) offs[idx] = $signed(val);
        else gains[idx - cha_pkg::CFG_GAIN_X] = val;
        @(posedge i_clk);
    endtask

    // one sample per call; expectation is formed at acceptance
    task automatic send_sample(logic [47:0] smp, bit known, t_result res);
        t_result pred;
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        do @(posedge i_clk); while (!s_axis_tready);
        pred = calibrate_sample(smp);
        if (known && pred != res) begin
            $display("table row disagrees with predictor");
            n_fail++;
        end
        expected_q.push_back(pred);
    endtask

    task automatic drain();
        int guard;
        s_axis_tvalid <= 1'b0;
        guard = 0;
        while (expected_q.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (40) @(posedge i_clk);
    endtask

    function automatic logic [47:0] rand_sample(int mode);
        logic [47:0] v;
        v = 48'({$urandom, $urandom});
        if (mode == 1) begin
            for (int a = 0; a < 3; a++)
                v[16*a +: 16] = ($urandom_range(1)) ? 16'h7fff : 16'h8000;
        end else if (mode == 2) begin
            for (int a = 0; a < 3; a++)
                v[16*a +: 16] = 16'($urandom_range(400) - 200);
        end
        return v;
    endfunction

    task automatic random_phase(int n);
        t_result none;
        none = '0;
        for (int k = 0; k < n; k++)
            send_sample(rand_sample($urandom_range(3) == 0 ? $urandom_range(2) : 0),
                        1'b0, none);
    endtask

    initial begin
        t_row tbl [$];
        t_row row;

        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = cha_pkg::CFG_OFFSET_X;
        i_cfg_data = '0;
        n_fail = 0;
        src_idle_pct = 11;
        snk_idle_pct = 82;
        ring_ptr = 0;
        for (int i = 0; i < 8; i++)
            for (int a = 0; a < 3; a++) ring[i][a] = 0;
        for (int a = 0; a < 3; a++) begin
            axis_sum[a] = 0;
            offs[a] = 0;
            gains[a] = 4096;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero sample after reset: all zero, zero vector heading
        row.sample = '0; row.known = 1; row.res = '0; tbl.push_back(row);
        // seven samples of 1000 along x fill the sum by steps of 1000; first avg is 125
        row.sample = {16'd0, 16'd0, 16'd1000}; row.known = 1;
        row.res = '{heading: 16'd0, cz: 16'd0, cy: 16'd0, cx: 16'd125};
        tbl.push_back(row);
        row.known = 0;
        for (int k = 0; k < 6; k++) begin
            row.sample = {16'd0, 16'd0, 16'd1000}; tbl.push_back(row);
        end
        // quadrant walk, extremes, negative x for half turn
        row.sample = {16'h8000, 16'h8000, 16'h8000}; tbl.push_back(row);
        row.sample = {16'h7fff, 16'h7fff, 16'h7fff}; tbl.push_back(row);
        for (int k = 0; k < 8; k++) begin
            row.sample = {16'h0000, 16'h0000, 16'hfc18}; tbl.push_back(row);
        end
        row.sample = {16'h0000, 16'hffff, 16'h7fff}; tbl.push_back(row);
        row.sample = {16'h1234, 16'h8000, 16'h0001}; tbl.push_back(row);
        row.sample = {16'h7fff, 16'h0001, 16'h8000}; tbl.push_back(row);
        foreach (tbl[i]) send_sample(tbl[i].sample, tbl[i].known, tbl[i].res);
        drain();

        // extreme offsets and gains: saturation both ways
        write_reg(cha_pkg::CFG_OFFSET_X, 16'h7fff);
        write_reg(cha_pkg::CFG_OFFSET_Y, 16'h8000);
        write_reg(cha_pkg::CFG_OFFSET_Z, 16'h0100);
        write_reg(cha_pkg::CFG_GAIN_X, 16'hffff);
        write_reg(cha_pkg::CFG_GAIN_Y, 16'h0000);
        write_reg(cha_pkg::CFG_GAIN_Z, 16'h2000);
        random_phase(300);
        drain();

        src_idle_pct = 82;
        snk_idle_pct = 11;
        write_reg(cha_pkg::CFG_OFFSET_X, 16'h8000);
        write_reg(cha_pkg::CFG_OFFSET_Y, 16'h7fff);
        write_reg(cha_pkg::CFG_OFFSET_Z, 16'hff00);
        write_reg(cha_pkg::CFG_GAIN_X, 16'h0001);
        write_reg(cha_pkg::CFG_GAIN_Y, 16'hffff);
        write_reg(cha_pkg::CFG_GAIN_Z, 16'h1000);
        random_phase(300);
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 2) begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            write_reg(cha_pkg::CFG_OFFSET_X, 16'($urandom_range(2000) - 1000));
            write_reg(cha_pkg::CFG_OFFSET_Y, 16'($urandom_range(2000) - 1000));
            write_reg(cha_pkg::CFG_OFFSET_Z, 16'($urandom));
            write_reg(cha_pkg::CFG_GAIN_X, 16'($urandom_range(3000, 6000)));
            write_reg(cha_pkg::CFG_GAIN_Y, 16'($urandom_range(3000, 6000)));
            write_reg(cha_pkg::CFG_GAIN_Z, 16'($urandom));
            random_phase(300);
            drain();
        end

        if (n_fail == 0 && expected_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
